// ----- hdl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared widths, fixed-point constants and register indexes of the Phong
// fragment shader.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // Default input field widths
    localparam int PFS_POS_WIDTH    = 20;
    localparam int PFS_NORMAL_WIDTH = 16;

    // Fixed-point layout
    localparam int FRAC      = 14;          // fraction bits of cosines and vectors
    localparam int ONE_Q14   = 16384;       // 1.0 in Q14
    localparam int COS_W     = 15;          // width of a saturated cosine [0, 1.0]
    localparam int CAM_W     = 20;          // camera field width
    localparam int NORM_BITS = 20;          // magnitude bits kept before the length
    localparam int LEN2_W    = 2 * NORM_BITS + 2;
    localparam int LEN_W     = NORM_BITS + 1;
    localparam int Q_W       = COS_W;       // view component magnitude width
    localparam int MAX_SHINE = 255;         // one power stage per exponent step
    localparam int SAT_SHIFT = 42;          // colour product saturates at 2^42

    localparam logic [7:0] ALPHA = 8'hFF;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_DIR   = 3'd0,
        REG_LIGHT_INT   = 3'd1,
        REG_DIFFUSE     = 3'd2,
        REG_SPECULAR    = 3'd3,
        REG_SHININESS   = 3'd4,
        REG_CAMERA      = 3'd5
    } cfg_reg_t;

endpackage

// ----- hdl/pfs_stream_if.sv -----
// ----------------------------------------------------------------------------
// pfs_stream_if
// Valid/ready channels for fragments in and pixels out.
// ----------------------------------------------------------------------------
interface pfs_frag_if #(
    parameter int POS_WIDTH    = pfs_pkg::PFS_POS_WIDTH,
    parameter int NORMAL_WIDTH = pfs_pkg::PFS_NORMAL_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [POS_WIDTH-1:0]    pos_x;
    logic signed [POS_WIDTH-1:0]    pos_y;
    logic signed [POS_WIDTH-1:0]    pos_z;
    logic signed [NORMAL_WIDTH-1:0] norm_x;
    logic signed [NORMAL_WIDTH-1:0] norm_y;
    logic signed [NORMAL_WIDTH-1:0] norm_z;
    logic                           last_fragment;

    modport source (
        output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_fragment,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_fragment,
        output ready
    );
endinterface

interface pfs_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_rgba;
    logic        last_pixel;

    modport source (output valid, pixel_rgba, last_pixel, input ready);
    modport sink   (input valid, pixel_rgba, last_pixel, output ready);
endinterface

// ----- hdl/phong_fragment_shader.sv -----
// Throughput: one fragment per cycle; the whole pipeline advances together
// and holds when the output register is full and not taken.
// Depth is set by the 255 power stages, the 21-stage square root and the
// 15-stage view divider.
// Reset clears all valid bits and loads register defaults (shininess 1).
// ----------------------------------------------------------------------------
// phong_fragment_shader
// Single directional light Phong shader, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module phong_fragment_shader #(
    parameter int POS_WIDTH    = pfs_pkg::PFS_POS_WIDTH,
    parameter int NORMAL_WIDTH = pfs_pkg::PFS_NORMAL_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data,
    pfs_frag_if.sink                       frag,
    pfs_pixel_if.source                    pixel
);
    import pfs_pkg::*;

    localparam int NW   = NORMAL_WIDTH;
    localparam int DW   = ((POS_WIDTH > CAM_W) ? POS_WIDTH : CAM_W) + 1;
    localparam int NLW  = NW + 17;
    localparam int SUMW = NLW + 2;
    localparam int CW   = ((NW + 5) > 17) ? (NW + 5) : 17;
    localparam int PW3  = CW + NW;
    localparam int RW   = PW3 + 2;
    localparam int SHW  = $clog2(DW);
    localparam int VPW  = RW + 16;
    localparam int RVW  = VPW + 2;
    localparam int SQW  = 2 * NORM_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] light_direction_reg;
    logic [47:0] light_intensity_reg;
    logic [47:0] diffuse_coeff_reg;
    logic [47:0] specular_coeff_reg;
    logic [7:0]  shininess_reg;
    logic [59:0] camera_position_reg;

    // Write the addressed register; drop indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_direction_reg <= '0;
            light_intensity_reg <= '0;
            diffuse_coeff_reg   <= '0;
            specular_coeff_reg  <= '0;
            shininess_reg       <= 8'd1;
            camera_position_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LIGHT_DIR: light_direction_reg <= cfg_data[47:0];
                REG_LIGHT_INT: light_intensity_reg <= cfg_data[47:0];
                REG_DIFFUSE:   diffuse_coeff_reg   <= cfg_data[47:0];
                REG_SPECULAR:  specular_coeff_reg  <= cfg_data[47:0];
                REG_SHININESS: shininess_reg       <= cfg_data[7:0];
                REG_CAMERA:    camera_position_reg <= cfg_data[59:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance
    // ------------------------------------------------------------------
    logic pixel_valid_reg;
    logic adv;

    assign adv        = !pixel_valid_reg || pixel.ready;
    assign frag.ready = adv;

    // ------------------------------------------------------------------
    // S1: N.L products, camera minus position
    // ------------------------------------------------------------------
    logic signed [POS_WIDTH-1:0] pos_c [3];
    logic signed [NW-1:0]        nrm_c [3];
    logic signed [16:0]          lgt_c [3];
    logic signed [CAM_W-1:0]     cam_c [3];

    logic                 v1_reg, l1_reg;
    logic signed [NLW-1:0] nl1_reg  [3];
    logic signed [NW-1:0]  nrm1_reg [3];
    logic signed [16:0]    lgt1_reg [3];
    logic signed [DW-1:0]  dir1_reg [3];

    always_comb
    begin
        pos_c[0] = frag.pos_x;
        pos_c[1] = frag.pos_y;
        pos_c[2] = frag.pos_z;
        nrm_c[0] = frag.norm_x;
        nrm_c[1] = frag.norm_y;
        nrm_c[2] = frag.norm_z;
        for (int i = 0; i < 3; i++)
        begin
            lgt_c[i] = -$signed({light_direction_reg[32-16*i+15],
                                 light_direction_reg[32-16*i +: 16]});
            cam_c[i] = $signed(camera_position_reg[CAM_W*(2-i) +: CAM_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= frag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg <= frag.last_fragment;
            for (int i = 0; i < 3; i++)
            begin
                nl1_reg[i]  <= NLW'(nrm_c[i]) * NLW'(lgt_c[i]);
                nrm1_reg[i] <= nrm_c[i];
                lgt1_reg[i] <= lgt_c[i];
                dir1_reg[i] <= DW'(cam_c[i]) - DW'(pos_c[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // S2: cosine of normal and light, direction magnitudes
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] nl_sum;
    logic signed [SUMW-1:0] nl_shr;

    logic                  v2_reg, l2_reg;
    logic signed [CW-1:0]  c2_reg;
    logic [DW-1:0]         mag2_reg [3];
    logic [2:0]            neg2_reg;
    logic signed [NW-1:0]  nrm2_reg [3];
    logic signed [16:0]    lgt2_reg [3];

    always_comb
    begin
        nl_sum = SUMW'(nl1_reg[0]) + SUMW'(nl1_reg[1]) + SUMW'(nl1_reg[2]);
        nl_shr = nl_sum >>> FRAC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l2_reg <= l1_reg;
            c2_reg <= CW'(nl_shr);
            for (int i = 0; i < 3; i++)
            begin
                neg2_reg[i] <= dir1_reg[i][DW-1];
                mag2_reg[i] <= dir1_reg[i][DW-1] ? DW'(-dir1_reg[i]) : DW'(dir1_reg[i]);
                nrm2_reg[i] <= nrm1_reg[i];
                lgt2_reg[i] <= lgt1_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // S3: c*N products, diffuse cosine, largest magnitude
    // ------------------------------------------------------------------
    logic [COS_W-1:0] dcos_c;
    logic [DW-1:0]    mmax_c;

    logic                  v3_reg, l3_reg;
    logic signed [PW3-1:0] prod3_reg [3];
    logic [COS_W-1:0]      dcos3_reg;
    logic [DW-1:0]         m3_reg;
    logic [DW-1:0]         mag3_reg [3];
    logic [2:0]            neg3_reg;
    logic signed [16:0]    lgt3_reg [3];

    always_comb
    begin
        if (c2_reg < 0)
        begin
            dcos_c = '0;
        end
        else if (c2_reg > CW'(ONE_Q14))
        begin
            dcos_c = COS_W'(ONE_Q14);
        end
        else
        begin
            dcos_c = c2_reg[COS_W-1:0];
        end
        mmax_c = (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
        if (mag2_reg[2] > mmax_c)
        begin
            mmax_c = mag2_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l3_reg    <= l2_reg;
            dcos3_reg <= dcos_c;
            m3_reg    <= mmax_c;
            neg3_reg  <= neg2_reg;
            for (int i = 0; i < 3; i++)
            begin
                prod3_reg[i] <= PW3'(c2_reg) * PW3'(nrm2_reg[i]);
                mag3_reg[i]  <= mag2_reg[i];
                lgt3_reg[i]  <= lgt2_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // S4: reflection vector, normalizing shift
    // ------------------------------------------------------------------
    logic signed [RW-1:0] prod_wide [3];
    logic signed [RW-1:0] refl_c    [3];
    logic [SHW-1:0]       shift_c;

    logic                 v4_reg, l4_reg;
    logic signed [RW-1:0] refl4_reg [3];
    logic [SHW-1:0]       s4_reg;
    logic [DW-1:0]        mag4_reg [3];
    logic [2:0]           neg4_reg;
    logic [COS_W-1:0]     dcos4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_wide[i] = RW'(prod3_reg[i]);
            refl_c[i]    = ((prod_wide[i] <<< 1) >>> FRAC) - RW'(lgt3_reg[i]);
        end
        // Highest set bit above the kept range sets the shift
        shift_c = '0;
        for (int k = NORM_BITS; k < DW; k++)
        begin
            if (m3_reg[k])
            begin
                shift_c = SHW'(k - NORM_BITS + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l4_reg    <= l3_reg;
            s4_reg    <= shift_c;
            neg4_reg  <= neg3_reg;
            dcos4_reg <= dcos3_reg;
            for (int i = 0; i < 3; i++)
            begin
                refl4_reg[i] <= refl_c[i];
                mag4_reg[i]  <= mag3_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // S5: scaled magnitudes
    // ------------------------------------------------------------------
    logic                 v5_reg, l5_reg;
    logic [NORM_BITS-1:0] e5_reg [3];
    logic signed [RW-1:0] refl5_reg [3];
    logic [2:0]           neg5_reg;
    logic [COS_W-1:0]     dcos5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l5_reg    <= l4_reg;
            neg5_reg  <= neg4_reg;
            dcos5_reg <= dcos4_reg;
            for (int i = 0; i < 3; i++)
            begin
                e5_reg[i]    <= NORM_BITS'(mag4_reg[i] >> s4_reg);
                refl5_reg[i] <= refl4_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // S6: squares
    // ------------------------------------------------------------------
    logic                 v6_reg, l6_reg;
    logic [SQW-1:0]       sq6_reg [3];
    logic [NORM_BITS-1:0] e6_reg [3];
    logic signed [RW-1:0] refl6_reg [3];
    logic [2:0]           neg6_reg;
    logic [COS_W-1:0]     dcos6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l6_reg    <= l5_reg;
            neg6_reg  <= neg5_reg;
            dcos6_reg <= dcos5_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq6_reg[i]   <= SQW'(e5_reg[i]) * SQW'(e5_reg[i]);
                e6_reg[i]    <= e5_reg[i];
                refl6_reg[i] <= refl5_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // S7: squared length
    // ------------------------------------------------------------------
    logic                 v7_reg, l7_reg;
    logic [LEN2_W-1:0]    len2_7_reg;
    logic [NORM_BITS-1:0] e7_reg [3];
    logic signed [RW-1:0] refl7_reg [3];
    logic [2:0]           neg7_reg;
    logic [COS_W-1:0]     dcos7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l7_reg     <= l6_reg;
            neg7_reg   <= neg6_reg;
            dcos7_reg  <= dcos6_reg;
            len2_7_reg <= LEN2_W'(sq6_reg[0]) + LEN2_W'(sq6_reg[1]) + LEN2_W'(sq6_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                e7_reg[i]    <= e6_reg[i];
                refl7_reg[i] <= refl6_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root, side data alongside
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic [COS_W-1:0]               dcos;
        logic [2:0][RW-1:0]             refl;
        logic [2:0]                     neg;
        logic [2:0][NORM_BITS-1:0]      e;
    } side_a_t;

    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic [COS_W-1:0]               dcos;
        logic [2:0][RW-1:0]             refl;
        logic [2:0]                     neg;
    } side_b_t;

    typedef struct packed {
        logic                           valid;
        logic                           last;
        logic [COS_W-1:0]               dcos;
    } side_c_t;

    side_a_t          side_a_in, side_a_out;
    logic [LEN_W-1:0] len;

    always_comb
    begin
        side_a_in.valid = v7_reg;
        side_a_in.last  = l7_reg;
        side_a_in.dcos  = dcos7_reg;
        side_a_in.neg   = neg7_reg;
        for (int i = 0; i < 3; i++)
        begin
            side_a_in.refl[i] = refl7_reg[i];
            side_a_in.e[i]    = e7_reg[i];
        end
    end

    pfs_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .n    (len2_7_reg),
        .root (len)
    );

    pfs_delay #(.W($bits(side_a_t)), .DEPTH(LEN_W)) u_side_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (side_a_in),
        .q     (side_a_out)
    );

    // ------------------------------------------------------------------
    // View direction dividers
    // ------------------------------------------------------------------
    side_b_t        side_b_in, side_b_out;
    logic [Q_W-1:0] quo [3];

    always_comb
    begin
        side_b_in.valid = side_a_out.valid;
        side_b_in.last  = side_a_out.last;
        side_b_in.dcos  = side_a_out.dcos;
        side_b_in.refl  = side_a_out.refl;
        side_b_in.neg   = side_a_out.neg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        pfs_div u_div (
            .clk (clk),
            .en  (adv),
            .mag (side_a_out.e[i]),
            .len (len),
            .quo (quo[i])
        );
    end

    pfs_delay #(.W($bits(side_b_t)), .DEPTH(Q_W)) u_side_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (side_b_in),
        .q     (side_b_out)
    );

    // ------------------------------------------------------------------
    // SV: R.V products
    // ------------------------------------------------------------------
    logic signed [15:0] view_c [3];

    logic                  vv_reg, lv_reg;
    logic signed [VPW-1:0] rvp_reg [3];
    logic [COS_W-1:0]      dcosv_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            view_c[i] = side_b_out.neg[i] ? -$signed({1'b0, quo[i]})
                                          : $signed({1'b0, quo[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg <= 1'b0;
        end
        else if (adv)
        begin
            vv_reg <= side_b_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lv_reg    <= side_b_out.last;
            dcosv_reg <= side_b_out.dcos;
            for (int i = 0; i < 3; i++)
            begin
                rvp_reg[i] <= VPW'($signed(side_b_out.refl[i])) * VPW'(view_c[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // SW: specular cosine
    // ------------------------------------------------------------------
    logic signed [RVW-1:0] rv_sum;
    logic signed [RVW-1:0] rv_shr;
    logic [COS_W-1:0]      rv_c;

    logic             vw_reg, lw_reg;
    logic [COS_W-1:0] rv_reg;
    logic [COS_W-1:0] dcosw_reg;

    always_comb
    begin
        rv_sum = RVW'(rvp_reg[0]) + RVW'(rvp_reg[1]) + RVW'(rvp_reg[2]);
        rv_shr = rv_sum >>> FRAC;
        if (rv_shr < 0)
        begin
            rv_c = '0;
        end
        else if (rv_shr > RVW'(ONE_Q14))
        begin
            rv_c = COS_W'(ONE_Q14);
        end
        else
        begin
            rv_c = rv_shr[COS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= 1'b0;
        end
        else if (adv)
        begin
            vw_reg <= vv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lw_reg    <= lv_reg;
            rv_reg    <= rv_c;
            dcosw_reg <= dcosv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Specular power
    // ------------------------------------------------------------------
    side_c_t          side_c_in, side_c_out;
    logic [COS_W-1:0] pw;

    always_comb
    begin
        side_c_in.valid = vw_reg;
        side_c_in.last  = lw_reg;
        side_c_in.dcos  = dcosw_reg;
    end

    pfs_power u_power (
        .clk       (clk),
        .en        (adv),
        .shininess (shininess_reg),
        .base      (rv_reg),
        .pw        (pw)
    );

    pfs_delay #(.W($bits(side_c_t)), .DEPTH(MAX_SHINE)) u_side_c (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .d     (side_c_in),
        .q     (side_c_out)
    );

    // ------------------------------------------------------------------
    // CA: coefficient products; CB1: sum; CB2: intensity product
    // ------------------------------------------------------------------
    logic        va_reg, la_reg;
    logic [30:0] pd_reg [3];
    logic [30:0] ps_reg [3];
    logic        vb1_reg, lb1_reg;
    logic [31:0] t_reg [3];
    logic        vb2_reg, lb2_reg;
    logic [47:0] vv2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg  <= side_c_out.valid;
            vb1_reg <= va_reg;
            vb2_reg <= vb1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            la_reg  <= side_c_out.last;
            lb1_reg <= la_reg;
            lb2_reg <= lb1_reg;
            for (int k = 0; k < 3; k++)
            begin
                pd_reg[k]  <= 31'(diffuse_coeff_reg[32-16*k +: 16]) * 31'(side_c_out.dcos);
                ps_reg[k]  <= 31'(specular_coeff_reg[32-16*k +: 16]) * 31'(pw);
                t_reg[k]   <= 32'(pd_reg[k]) + 32'(ps_reg[k]);
                vv2_reg[k] <= 48'(light_intensity_reg[32-16*k +: 16]) * 48'(t_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: saturate, quantize, pack
    // ------------------------------------------------------------------
    logic [SAT_SHIFT:0]   vsat_c  [3];
    logic [SAT_SHIFT+8:0] scale_c [3];
    logic [7:0]           byte_c  [3];
    logic [31:0]          pixel_rgba_reg;
    logic                 last_pixel_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (vv2_reg[k] > 48'(1) << SAT_SHIFT)
            begin
                vsat_c[k] = (SAT_SHIFT+1)'(1) << SAT_SHIFT;
            end
            else
            begin
                vsat_c[k] = vv2_reg[k][SAT_SHIFT:0];
            end
            scale_c[k] = {vsat_c[k], 8'd0} - (SAT_SHIFT+9)'(vsat_c[k]);
            byte_c[k]  = scale_c[k][SAT_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pixel_valid_reg <= vb2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_rgba_reg <= {byte_c[0], byte_c[1], byte_c[2], ALPHA};
            last_pixel_reg <= lb2_reg;
        end
    end

    assign pixel.valid      = pixel_valid_reg;
    assign pixel.pixel_rgba = pixel_rgba_reg;
    assign pixel.last_pixel = last_pixel_reg;
endmodule

// ----- hdl/pfs_delay.sv -----
// ----------------------------------------------------------------------------
// pfs_delay
// Enabled shift line that carries side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module pfs_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [DEPTH];

    // Shift one place per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                tap_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

// ----- hdl/pfs_isqrt.sv -----
// ----------------------------------------------------------------------------
// pfs_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pfs_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [pfs_pkg::LEN2_W-1:0] n,
    output logic [pfs_pkg::LEN_W-1:0]  root
);
    import pfs_pkg::*;

    localparam int STEPS = LEN_W;
    localparam int RW    = LEN2_W + 1;

    logic [RW-1:0] n_reg [STEPS];
    logic [RW-1:0] r_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - k));
        logic [RW-1:0] n_in;
        logic [RW-1:0] r_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] n_next;
        logic [RW-1:0] r_next;

        if (k == 0)
        begin : g_first
            assign n_in = RW'(n);
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        // Try this bit of the root
        always_comb
        begin
            trial = r_in + BIT;
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[STEPS-1][LEN_W-1:0];
endmodule

// ----- hdl/pfs_div.sv -----
// ----------------------------------------------------------------------------
// pfs_div
// Pipelined restoring divider: (mag << 14) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pfs_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [pfs_pkg::NORM_BITS-1:0] mag,
    input  logic [pfs_pkg::LEN_W-1:0]     len,
    output logic [pfs_pkg::Q_W-1:0]       quo
);
    import pfs_pkg::*;

    localparam int STEPS = Q_W;
    localparam int NUM_W = NORM_BITS + FRAC;
    localparam int DV_W  = LEN_W + Q_W - 1;

    logic [NUM_W-1:0] rem_reg [STEPS];
    logic [Q_W-1:0]   q_reg   [STEPS];
    logic [LEN_W-1:0] len_reg [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int B = STEPS - 1 - k;
        logic [NUM_W-1:0] rem_in;
        logic [Q_W-1:0]   q_in;
        logic [LEN_W-1:0] len_in;
        logic [DV_W-1:0]  dv;
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = {mag, {FRAC{1'b0}}};
            assign q_in   = '0;
            assign len_in = len;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign len_in = len_reg[k-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb
        begin
            dv = DV_W'(len_in) << B;
            if (DV_W'(rem_in) >= dv)
            begin
                rem_next = rem_in - dv[NUM_W-1:0];
                q_next   = q_in | (Q_W'(1) << B);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                len_reg[k] <= len_in;
            end
        end
    end

    // Zero length means a zero view vector
    assign quo = (len_reg[STEPS-1] == '0) ? '0 : q_reg[STEPS-1];
endmodule

// ----- hdl/pfs_power.sv -----
// ----------------------------------------------------------------------------
// pfs_power
// Specular power: one Q14 multiply per stage, applied while the stage index
// is below the shininess exponent.
// ----------------------------------------------------------------------------
module pfs_power (
    input  logic                      clk,
    input  logic                      en,
    input  logic [7:0]                shininess,
    input  logic [pfs_pkg::COS_W-1:0] base,
    output logic [pfs_pkg::COS_W-1:0] pw
);
    import pfs_pkg::*;

    localparam int STAGES = MAX_SHINE;

    logic [COS_W-1:0] p_reg [STAGES];
    logic [COS_W-1:0] b_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [COS_W-1:0]   p_in;
        logic [COS_W-1:0]   b_in;
        logic [2*COS_W-1:0] prod;
        logic [COS_W-1:0]   p_next;

        if (k == 0)
        begin : g_first
            assign p_in = COS_W'(ONE_Q14);
            assign b_in = base;
        end
        else
        begin : g_rest
            assign p_in = p_reg[k-1];
            assign b_in = b_reg[k-1];
        end

        // Multiply once more or pass through
        always_comb
        begin
            prod = (2*COS_W)'(p_in) * (2*COS_W)'(b_in);
            if (8'(k) < shininess)
            begin
                p_next = prod[FRAC +: COS_W];
            end
            else
            begin
                p_next = p_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k] <= p_next;
                b_reg[k] <= b_in;
            end
        end
    end

    assign pw = p_reg[STAGES-1];
endmodule

// ----- hdl/pfs_checker.sv -----
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks of the shader, bound to the top level.
// ----------------------------------------------------------------------------
module pfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_rgba,
    input logic        out_last
);
    import pfs_pkg::*;

    // Hold a stalled pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rgba) && $stable(out_last))
        else $error("stalled pixel changed");

    // An empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Alpha is always opaque
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rgba[7:0] == ALPHA)
        else $error("alpha not opaque");

    // A pixel rises only out of an advance of the pipeline (input ready)
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("pixel appeared while pipeline stalled");
endmodule

bind phong_fragment_shader pfs_checker u_pfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (frag.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .out_rgba  (pixel.pixel_rgba),
    .out_last  (pixel.last_pixel)
);
